@@ src/mabrc_pkg.sv @@
`default_nettype none
package mabrc_pkg;
  localparam int unsigned ElemW = 64;
  localparam int unsigned PosW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REDUCE_MODE = 2'd0,
    REG_ELEM_TYPE   = 2'd1,
    REG_NUM_COLS    = 2'd2,
    REG_NUM_ROWS    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    TYPE_I16 = 3'd0,
    TYPE_I32 = 3'd1,
    TYPE_F32 = 3'd2,
    TYPE_F64 = 3'd3,
    TYPE_I64 = 3'd4
  } elem_type_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CMP,
    ST_DRAIN
  } state_t;

  // ordered key for a float: flip all bits if negative, else flip sign
  function automatic logic [63:0] fkey64(input logic [63:0] v);
    fkey64 = v[63] ? ~v : {1'b1, v[62:0]};
  endfunction

  // true when candidate a is strictly greater than held b
  function automatic logic greater(input logic [2:0] t, input logic [63:0] a,
                                   input logic [63:0] b);
    logic a_nan32, b_nan32, a_nan64, b_nan64;
    logic [31:0] a32, b32;
    logic [63:0] ka, kb;
    a32 = a[31:0];
    b32 = b[31:0];
    a_nan32 = (a32[30:23] == 8'hFF) && (a32[22:0] != '0);
    b_nan32 = (b32[30:23] == 8'hFF) && (b32[22:0] != '0);
    a_nan64 = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
    b_nan64 = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
    ka = '0;
    kb = '0;
    greater = 1'b0;
    case (t)
      TYPE_I16: greater = $signed(a[15:0]) > $signed(b[15:0]);
      TYPE_I32: greater = $signed(a[31:0]) > $signed(b[31:0]);
      TYPE_F32: begin
        ka = fkey64({a32, 32'd0});
        kb = fkey64({b32, 32'd0});
        // zeros of either sign compare equal
        if (a_nan32 || b_nan32) greater = 1'b0;
        else if (a32[30:0] == '0 && b32[30:0] == '0) greater = 1'b0;
        else greater = ka > kb;
      end
      TYPE_F64: begin
        ka = fkey64(a);
        kb = fkey64(b);
        if (a_nan64 || b_nan64) greater = 1'b0;
        else if (a[62:0] == '0 && b[62:0] == '0) greater = 1'b0;
        else greater = ka > kb;
      end
      default: greater = $signed(a) > $signed(b);
    endcase
  endfunction
endpackage
`default_nettype wire

@@ src/mabrc_if.sv @@
`default_nettype none
interface mabrc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] elem_bits;
  modport source (output valid, output elem_bits, input ready);
  modport sink (input valid, input elem_bits, output ready);
endinterface

interface mabrc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_pos;
  logic [15:0] line_num;
  logic        last;
  modport source (output valid, output max_pos, output line_num, output last, input ready);
  modport sink (input valid, input max_pos, input line_num, input last, output ready);
endinterface

interface mabrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/mabrc_ram.sv @@
`default_nettype none
module mabrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/matrix_argmax_by_row_or_column.sv @@
`default_nettype none
// channel | dir | words
// in      | in  | elem_bits, one matrix element in row-major order
// out     | out | max_pos, line_num, last
// cfg     | in  | index, data; register write
// row mode: one element per cycle while no result waits; at each row end input stalls until the result is taken
// column mode: each element gets a table read, then a compare and write back; the next element waits for the compare
// end of a column-mode matrix: one result per column; each is read from the table, then
// presented, then held until the receiver takes it
// a result waits in the output register while input stays stalled
// rst clears registers to defaults and position counters; the table needs no clear
module matrix_argmax_by_row_or_column
  import mabrc_pkg::*;
#(
  parameter int unsigned MAX_COLS = 64
) (
  input wire logic clk,
  input wire logic rst,
  mabrc_in_if.sink   in_ch,
  mabrc_out_if.source out_ch,
  mabrc_cfg_if.sink  cfg
);
  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  // configuration
  logic        reduce_mode;
  logic [2:0]  elem_type;
  logic [6:0]  num_cols;
  logic [15:0] num_rows;

  // positions and row-mode running maximum
  logic [AW-1:0] col_pos, col_pos_next;
  logic [15:0]   row_pos, row_pos_next;
  logic [63:0]   run_max;
  logic [AW-1:0] run_pos;

  state_t state, state_next;

  // held element and its position during a column-mode compare
  logic [63:0]   hold_elem;
  logic [AW-1:0] hold_col;
  logic [15:0]   hold_row;
  logic          hold_mat_end;
  logic [AW-1:0] drain_col;
  logic          drain_rd;   // table read data valid for drain_col

  // output register
  logic          out_valid;
  logic [15:0]   out_pos, out_line;
  logic          out_last;

  // effective counts
  logic [CW-1:0] cols_eff;
  logic [15:0]   rows_eff;
  always_comb begin
    if (num_cols == '0) cols_eff = CW'(1);
    else if (32'(num_cols) > MAX_COLS) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(num_cols);
    rows_eff = (num_rows == '0) ? 16'd1 : num_rows;
  end

  logic          in_fire, cfg_fire, out_fire;
  logic          row_end, mat_end;
  assign cfg_fire = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;
  assign out_fire = out_valid && out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  // accept only with the output register free, no compare or drain pending, no cfg.valid
  assign in_ch.ready = (state == ST_RUN) && !out_valid && !cfg.valid;

  assign row_end = ((CW+1)'(col_pos) + (CW+1)'(1)) == (CW+1)'(cols_eff);
  assign mat_end = row_end && ((17'(row_pos) + 17'd1) == 17'(rows_eff));

  // table: best value and row per column
  logic          tbl_we;
  logic [AW-1:0] tbl_waddr, tbl_raddr;
  logic [63:0]   val_rdata;
  logic [15:0]   row_rdata;
  mabrc_ram #(.Width(64), .Depth(MAX_COLS)) u_val (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(hold_elem),
    .raddr(tbl_raddr), .rdata(val_rdata)
  );
  mabrc_ram #(.Width(16), .Depth(MAX_COLS)) u_row (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(hold_row),
    .raddr(tbl_raddr), .rdata(row_rdata)
  );

  logic cmp_win;
  assign cmp_win  = (hold_row == '0) || greater(elem_type, hold_elem, val_rdata);
  assign tbl_we   = (state == ST_CMP) && cmp_win;
  assign tbl_waddr = hold_col;
  // in drain, read the next column ahead
  assign tbl_raddr = (state == ST_RUN) ? col_pos : drain_col;

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: if (in_fire && reduce_mode) state_next = ST_CMP;
      ST_CMP: state_next = hold_mat_end ? ST_DRAIN : ST_RUN;
      ST_DRAIN:
        if (out_fire && out_last) state_next = ST_RUN;
      default: state_next = ST_RUN;
    endcase
  end

  // position update
  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    if (in_fire) begin
      if (row_end) begin
        col_pos_next = '0;
        row_pos_next = mat_end ? 16'd0 : row_pos + 16'd1;
      end else begin
        col_pos_next = col_pos + AW'(1);
      end
    end
  end

  logic row_win;
  assign row_win = (col_pos == '0) || greater(elem_type, in_ch.elem_bits, run_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= 1'b0;
      elem_type   <= TYPE_I32;
      num_cols    <= 7'd64;
      num_rows    <= 16'd1;
      col_pos     <= '0;
      row_pos     <= '0;
      run_max     <= '0;
      run_pos     <= '0;
      state       <= ST_RUN;
      out_valid   <= 1'b0;
      drain_col   <= '0;
      drain_rd    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        case (reg_idx_t'(cfg.index))
          REG_REDUCE_MODE: reduce_mode <= cfg.data[0];
          REG_ELEM_TYPE:   elem_type   <= cfg.data[2:0];
          REG_NUM_COLS:    num_cols    <= cfg.data[6:0];
          REG_NUM_ROWS:    num_rows    <= cfg.data;
          default: ;
        endcase
        col_pos <= '0;
        row_pos <= '0;
        run_max <= '0;
        run_pos <= '0;
      end else begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
      end
      if (out_fire) out_valid <= 1'b0;
      // row mode
      if (in_fire && !reduce_mode) begin
        if (row_win) begin
          run_max <= in_ch.elem_bits;
          run_pos <= col_pos;
        end
        if (row_end) begin
          out_valid <= 1'b1;
          out_pos   <= 16'(row_win ? col_pos : run_pos);
          out_line  <= row_pos;
          out_last  <= mat_end;
        end
      end
      // column mode capture
      if (in_fire && reduce_mode) begin
        hold_elem    <= in_ch.elem_bits;
        hold_col     <= col_pos;
        hold_row     <= row_pos;
        hold_mat_end <= mat_end;
      end
      if (state == ST_CMP && hold_mat_end) begin
        drain_col <= '0;
        drain_rd  <= 1'b0;
      end
      // drain: read column, then present it
      if (state == ST_DRAIN) begin
        if (!drain_rd && !out_valid) begin
          drain_rd <= 1'b1;
        end else if (drain_rd && !out_valid) begin
          out_valid <= 1'b1;
          out_pos   <= row_rdata;
          out_line  <= 16'(drain_col);
          out_last  <= ((CW+1)'(drain_col) + (CW+1)'(1)) == (CW+1)'(cols_eff);
          drain_rd  <= 1'b0;
          drain_col <= drain_col + AW'(1);
        end
      end
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.max_pos  = out_pos;
  assign out_ch.line_num = out_line;
  assign out_ch.last     = out_last;
endmodule
`default_nettype wire

@@ test/matrix_argmax_by_row_or_column_test.sv @@
module matrix_argmax_by_row_or_column_test;
  import mabrc_pkg::*;

  localparam int unsigned StallLimit = 5000;  // cycles with no accepted word
  localparam int unsigned SettleCycles = 12;  // covers the compare and drain start

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] line;
    logic        last;
  } argmax_word_t;

  // running argmax predictor plus the queue of results it still owes
  class argmax_board;
    bit           failed;
    argmax_word_t owed[$];
    bit           by_col;
    logic [2:0]   etype;
    int unsigned  cols, rows, col_pos, row_pos, run_pos;
    logic [63:0]  run_max;
    logic [63:0]  best_val[64];
    logic [15:0]  best_row[64];

    function new();
      failed = 0;
      by_col = 0;
      etype = TYPE_I32;
      cols = 64;
      rows = 1;
      restart();
    endfunction

    function void restart();
      col_pos = 0;
      row_pos = 0;
      run_max = '0;
      run_pos = 0;
    endfunction

    // float order: nan never wins, zeros of either sign are equal
    function bit fp_gt(bit sa, logic [62:0] ma, bit na, bit sb, logic [62:0] mb, bit nb);
      if (na || nb) return 0;
      if (ma == '0 && mb == '0) return 0;
      if (sa != sb) return !sa;
      return sa ? (ma < mb) : (ma > mb);
    endfunction

    function bit beats(logic [63:0] a, logic [63:0] b);
      case (etype)
        TYPE_I16: return $signed(a[15:0]) > $signed(b[15:0]);
        TYPE_I32: return $signed(a[31:0]) > $signed(b[31:0]);
        TYPE_F32: return fp_gt(a[31], {32'd0, a[30:0]},
                               a[30:23] == 8'hFF && a[22:0] != '0,
                               b[31], {32'd0, b[30:0]},
                               b[30:23] == 8'hFF && b[22:0] != '0);
        TYPE_F64: return fp_gt(a[63], a[62:0], a[62:52] == 11'h7FF && a[51:0] != '0,
                               b[63], b[62:0], b[62:52] == 11'h7FF && b[51:0] != '0);
        default: return $signed(a) > $signed(b);
      endcase
    endfunction

    function void configure(reg_idx_t idx, logic [15:0] value);
      case (idx)
        REG_REDUCE_MODE: by_col = value[0];
        REG_ELEM_TYPE:   etype = value[2:0];
        REG_NUM_COLS:    cols = 32'(value[6:0]);
        REG_NUM_ROWS:    rows = 32'(value);
        default: ;
      endcase
      restart();
    endfunction

    function void note_elem(logic [63:0] e);
      int unsigned c_lim, r_lim;
      bit row_end, mat_end;
      c_lim = (cols == 0) ? 1 : ((cols > 64) ? 64 : cols);
      r_lim = (rows == 0) ? 1 : rows;
      if (col_pos >= c_lim) col_pos = 0;
      if (row_pos >= r_lim) row_pos = 0;
      row_end = (col_pos + 1 == c_lim);
      mat_end = row_end && (row_pos + 1 == r_lim);
      if (!by_col) begin
        if (col_pos == 0 || beats(e, run_max)) begin
          run_max = e;
          run_pos = col_pos;
        end
        if (row_end) owed.push_back('{16'(run_pos), 16'(row_pos), mat_end});
      end else begin
        if (row_pos == 0 || beats(e, best_val[col_pos])) begin
          best_val[col_pos] = e;
          best_row[col_pos] = 16'(row_pos);
        end
        if (mat_end)
          for (int unsigned k = 0; k < c_lim; k++)
            owed.push_back('{best_row[k], 16'(k), k + 1 == c_lim});
      end
      if (row_end) begin
        col_pos = 0;
        row_pos = mat_end ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void check_result(argmax_word_t got);
      argmax_word_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result pos %h line %h last %b",
                 $time, got.pos, got.line, got.last);
        failed = 1;
        return;
      end
      want = owed.pop_front();
      if (got.pos !== want.pos) begin
        $display("%0t: max_pos expected %h actual %h", $time, want.pos, got.pos);
        failed = 1;
      end
      if (got.line !== want.line) begin
        $display("%0t: line_num expected %h actual %h", $time, want.line, got.line);
        failed = 1;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        failed = 1;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  mabrc_in_if  in_ch();
  mabrc_out_if out_ch();
  mabrc_cfg_if cfg();

  matrix_argmax_by_row_or_column dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  argmax_board board = new();

  int unsigned send_gap_pct = 0;   // chance per cycle that the sender holds off
  int unsigned sink_stall_pct = 0; // chance per cycle that the receiver stalls
  int unsigned quiet_cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver side: ready is drawn at random each cycle from the phase's stall chance
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // check each result word as it is taken
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.max_pos, out_ch.line_num, out_ch.last});
  end

  // watchdog: any accepted word on any channel resets the count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("matrix_argmax_by_row_or_column verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one element word; valid stays high into the next call unless a gap is drawn
  task automatic push_elem(logic [63:0] w);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.elem_bits <= w;
    do @(posedge clk); while (!in_ch.ready);
    board.note_elem(w);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    board.configure(idx, value);
  endtask

  // wait out every owed result, then let the compare pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.owed.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_matrix(bit by_col, logic [2:0] et, logic [6:0] nc, logic [15:0] nr);
    write_reg(REG_REDUCE_MODE, {15'd0, by_col});
    write_reg(REG_ELEM_TYPE, {13'd0, et});
    write_reg(REG_NUM_COLS, {9'd0, nc});
    write_reg(REG_NUM_ROWS, nr);
  endtask

  // mix of raw random bits, near-ties, float specials and integer extremes
  function automatic logic [63:0] pick_elem();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(9))
      4, 5: begin
        w = 64'($urandom_range(3));
        if ($urandom_range(1)) w = -w;
      end
      6: case ($urandom_range(7))
        0: w = {w[63:32], 32'h7FC00000};         // f32 quiet nan
        1: w = {w[63:32], 32'hFF800000};         // f32 -inf
        2: w = {w[63:32], 32'h7F800000};         // f32 +inf
        3: w = {w[63:32], 32'h80000000};         // f32 -0
        4: w = 64'h7FF8000000000001;             // f64 nan
        5: w = 64'hFFF0000000000000;             // f64 -inf
        6: w = 64'h7FF0000000000000;             // f64 +inf
        default: w = 64'h8000000000000000;       // f64 -0 and int64 min
      endcase
      7: case ($urandom_range(3))
        0: w = {w[63:16], 16'h7FFF};
        1: w = {w[63:16], 16'h8000};
        2: w = {w[63:32], 32'h7FFFFFFF};
        default: w = 64'h7FFFFFFFFFFFFFFF;
      endcase
      default: ;
    endcase
    return w;
  endfunction

  typedef struct {
    bit          by_col;
    logic [2:0]  et;
    logic [6:0]  nc;
    logic [15:0] nr;
    int unsigned count;
  } phase_t;

  phase_t plan[12];
  logic [63:0] f32_words[12];
  logic [63:0] f64_words[8];

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.elem_bits <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_REDUCE_MODE;
    cfg.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: f32 rows with a nan opening the row, signed zeros, infinities, ties
    f32_words = '{64'h7FC00000, 64'h7F800000, 64'h3F800000, 64'h00000000,
                  64'h80000000, 64'h00000000, 64'hFF800000, 64'hBF800000,
                  64'h3F800000, 64'h3F800000, 64'h7F800001, 64'h7F800000};
    set_matrix(1'b0, TYPE_F32, 7'd4, 16'd3);
    foreach (f32_words[i]) push_elem(f32_words[i]);
    drain_results();

    // directed: f64 columns, nan in the first row holds its column
    f64_words = '{64'h7FF8000000000000, 64'h8000000000000000,
                  64'hFFF0000000000000, 64'h4000000000000000,
                  64'h7FF0000000000000, 64'h0000000000000000,
                  64'hC000000000000000, 64'h4000000000000000};
    set_matrix(1'b1, TYPE_F64, 7'd4, 16'd2);
    foreach (f64_words[i]) push_elem(f64_words[i]);
    drain_results();

    // random phases; the rows-max phases stop partway and restart on the next write
    plan = '{'{0, 3'd0, 7'd5,   16'd4,     20}, '{1, 3'd0, 7'd3,  16'd3,     18},
             '{1, 3'd2, 7'd4,   16'd4,     16}, '{0, 3'd3, 7'd6,  16'd2,     12},
             '{1, 3'd3, 7'd2,   16'd5,     20}, '{0, 3'd4, 7'd64, 16'd1,     64},
             '{1, 3'd5, 7'd0,   16'd0,      3}, '{1, 3'd7, 7'd127, 16'd1,    64},
             '{0, 3'd6, 7'd1,   16'd65535, 20}, '{1, 3'd1, 7'd7,  16'd65535, 10},
             '{0, 3'd1, 7'd3,   16'd2,     18}, '{1, 3'd4, 7'd2,  16'd1,      4}};
    foreach (plan[p]) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_gap_pct = 48; sink_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  sink_stall_pct = 48; end
        default: begin send_gap_pct = 26; sink_stall_pct = 26; end
      endcase
      set_matrix(plan[p].by_col, plan[p].et, plan[p].nc, plan[p].nr);
      repeat (plan[p].count) push_elem(pick_elem());
      drain_results();
    end

    if (!board.failed && board.owed.size() == 0) begin
      $display("matrix_argmax_by_row_or_column verification clean");
    end else begin
      $display("matrix_argmax_by_row_or_column verification failed");
    end
    $finish;
  end
endmodule
